[rtl/ffba_pkg.sv]
// Shared constants, codes and types of the first-fit block allocator.
package ffba_pkg;

  // Arena geometry
  localparam int ARENA_UNITS  = 1024;
  localparam int HEADER_UNITS = 2;
  localparam int OFF_W        = $clog2(ARENA_UNITS);
  localparam int SIZE_W       = OFF_W;
  // ALU result: headroom for offset + size + header, plus a sign bit
  localparam int SUM_W        = OFF_W + 2;
  localparam int STATUS_W     = 2;

  // Request function codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_EXACT = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SPLIT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FREE  = 2'd3;

  // Operations of the shared add/subtract unit
  typedef enum logic [1:0] {
    ALU_ADD_HDR,   // a + b + header
    ALU_SUB,       // a - b
    ALU_SUB_HDR    // a - b - header
  } alu_op_t;

  // Header store access from the sequencer
  typedef struct packed {
    logic              rd_en;
    logic [OFF_W-1:0]  rd_addr;
    logic              wr_size_en;
    logic              wr_free_en;
    logic [OFF_W-1:0]  wr_addr;
    logic [SIZE_W-1:0] wr_size;
    logic              wr_free;
  } hdr_req_t;

endpackage

[rtl/ffba_if.sv]
// Request and result channel interfaces of the block allocator.
interface ffba_in_if import ffba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [SIZE_W-1:0] alloc_size;
  logic [OFF_W-1:0]  address;

  modport source (output valid, func, alloc_size, address, input ready);
  modport sink   (input valid, func, alloc_size, address, output ready);
endinterface

interface ffba_out_if import ffba_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [OFF_W-1:0]    payload_addr;

  modport source (output valid, status, payload_addr, input ready);
  modport sink   (input valid, status, payload_addr, output ready);
endinterface

[rtl/ffba_alu.sv]
// Shared add/subtract unit used by the arithmetic steps of the allocator sequencer.
module ffba_alu import ffba_pkg::*; (
  input  alu_op_t           op,
  input  logic [OFF_W-1:0]  a,
  input  logic [OFF_W-1:0]  b,
  output logic [SUM_W-1:0]  res
);

  logic             sub;
  logic             hdr;
  logic [SUM_W-1:0] bx;

  // decode operation
  always_comb begin
    case (op)
      ALU_ADD_HDR: begin sub = 1'b0; hdr = 1'b1; end
      ALU_SUB:     begin sub = 1'b1; hdr = 1'b0; end
      ALU_SUB_HDR: begin sub = 1'b1; hdr = 1'b1; end
      default:     begin sub = 1'b0; hdr = 1'b0; end
    endcase
  end

  // header added to b, then one adder subtracts by inverting b and carrying in
  always_comb begin
    bx  = SUM_W'(b) + (hdr ? SUM_W'(HEADER_UNITS) : '0);
    res = SUM_W'(a) + (bx ^ {SUM_W{sub}}) + SUM_W'(sub);
  end

endmodule

[rtl/ffba_hdr_store.sv]
// Block header store: size and free mark per arena offset, entry 0 in flops.
module ffba_hdr_store import ffba_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  hdr_req_t          req,
  output logic [SIZE_W-1:0] rd_size,
  output logic              rd_free
);

  logic [SIZE_W-1:0] size_mem [ARENA_UNITS];
  logic              free_mem [ARENA_UNITS];

  logic [SIZE_W-1:0] size_q_r;
  logic              free_q_r;
  logic [SIZE_W-1:0] e0_size_r;
  logic              e0_free_r;
  logic              sel0_r;

  // memories: one write and one registered read per cycle each
  always_ff @(posedge clk) begin
    if (req.wr_size_en && (req.wr_addr != '0)) begin
      size_mem[req.wr_addr] <= req.wr_size;
    end
    if (req.wr_free_en && (req.wr_addr != '0)) begin
      free_mem[req.wr_addr] <= req.wr_free;
    end
    if (req.rd_en) begin
      size_q_r <= size_mem[req.rd_addr];
      free_q_r <= free_mem[req.rd_addr];
    end
  end

  // entry 0 holds the whole arena after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e0_size_r <= SIZE_W'(ARENA_UNITS - HEADER_UNITS);
      e0_free_r <= 1'b1;
      sel0_r    <= 1'b1;
    end else begin
      if (req.wr_size_en && (req.wr_addr == '0)) begin
        e0_size_r <= req.wr_size;
      end
      if (req.wr_free_en && (req.wr_addr == '0)) begin
        e0_free_r <= req.wr_free;
      end
      if (req.rd_en) begin
        sel0_r <= (req.rd_addr == '0);
      end
    end
  end

  assign rd_size = sel0_r ? e0_size_r : size_q_r;
  assign rd_free = sel0_r ? e0_free_r : free_q_r;

endmodule

[rtl/first_fit_block_allocator.sv]
// Steps: a free checks the range, then marks the header free; an allocate walks the blocks
//   from offset 0 through the header store read port, then writes the split headers and result.
// Throughput: one request at a time; next request taken when the sequencer is idle,
//   even while the previous result still waits in the output register.
// Reset: synchronous, active low; arena becomes one free block at once, no clearing pass.
module first_fit_block_allocator import ffba_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  ffba_in_if.sink    in_ch,
  ffba_out_if.source out_ch
);

  typedef enum logic [3:0] {
    S_IDLE, S_FCHK, S_FWR, S_RD, S_NXT, S_CHK,
    S_SPL1, S_SPL2, S_WR1, S_WR2, S_EXW, S_RESP
  } state_t;

  state_t              state_r, state_nxt;
  logic [SIZE_W-1:0]   req_r, req_nxt;
  logic [OFF_W-1:0]    cur_r, cur_nxt;
  logic [OFF_W-1:0]    next_r, next_nxt;
  logic [SIZE_W-1:0]   sz_r, sz_nxt;
  logic                fr_r, fr_nxt;
  logic                last_r, last_nxt;
  logic [SIZE_W-1:0]   rsz_r, rsz_nxt;
  logic [OFF_W-1:0]    rst_r, rst_nxt;
  logic                rest_ok_r, rest_ok_nxt;
  logic [STATUS_W-1:0] st_r, st_nxt;
  logic [OFF_W-1:0]    pay_r, pay_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [OFF_W-1:0]    out_addr_r, out_addr_nxt;

  hdr_req_t            hdr_req;
  logic [SIZE_W-1:0]   rd_size;
  logic                rd_free;
  alu_op_t             alu_op;
  logic [OFF_W-1:0]    alu_a;
  logic [OFF_W-1:0]    alu_b;
  logic [SUM_W-1:0]    alu_res;
  logic                alu_neg;
  logic                alu_zero;
  logic                in_acc;

  ffba_hdr_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (hdr_req),
    .rd_size (rd_size),
    .rd_free (rd_free)
  );

  ffba_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  assign alu_neg  = alu_res[SUM_W-1];
  assign alu_zero = (alu_res == '0);
  assign in_acc   = in_ch.valid && in_ch.ready;

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.payload_addr = out_addr_r;

  // sequencer next state and datapath
  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    cur_nxt        = cur_r;
    next_nxt       = next_r;
    sz_nxt         = sz_r;
    fr_nxt         = fr_r;
    last_nxt       = last_r;
    rsz_nxt        = rsz_r;
    rst_nxt        = rst_r;
    rest_ok_nxt    = rest_ok_r;
    st_nxt         = st_r;
    pay_nxt        = pay_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    hdr_req        = '0;
    alu_op         = ALU_ADD_HDR;
    alu_a          = '0;
    alu_b          = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          req_nxt = in_ch.alloc_size;
          pay_nxt = '0;
          if (in_ch.func == FUNC_FREE) begin
            cur_nxt   = in_ch.address;
            state_nxt = S_FCHK;
          end else if (in_ch.alloc_size == '0) begin
            st_nxt    = ST_NOFIT;
            state_nxt = S_RESP;
          end else begin
            cur_nxt   = '0;
            state_nxt = S_RD;
          end
        end
      end
      // header offset of the freed payload, range check
      S_FCHK: begin
        alu_op = ALU_SUB_HDR;
        alu_a  = cur_r;
        st_nxt = ST_FREE;
        if (!alu_neg && (alu_res < SUM_W'(ARENA_UNITS))) begin
          cur_nxt   = alu_res[OFF_W-1:0];
          state_nxt = S_FWR;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_FWR: begin
        hdr_req.wr_free_en = 1'b1;
        hdr_req.wr_addr    = cur_r;
        hdr_req.wr_free    = 1'b1;
        state_nxt          = S_RESP;
      end
      // walk: fetch the header at cur
      S_RD: begin
        hdr_req.rd_en   = 1'b1;
        hdr_req.rd_addr = cur_r;
        state_nxt       = S_NXT;
      end
      // successor offset and last-block test
      S_NXT: begin
        alu_op   = ALU_ADD_HDR;
        alu_a    = cur_r;
        alu_b    = rd_size;
        sz_nxt   = rd_size;
        fr_nxt   = rd_free;
        last_nxt = (alu_res >= SUM_W'(ARENA_UNITS));
        next_nxt = alu_res[OFF_W-1:0];
        if (rd_free) begin
          state_nxt = S_CHK;
        end else if (alu_res >= SUM_W'(ARENA_UNITS)) begin
          st_nxt    = ST_NOFIT;
          state_nxt = S_RESP;
        end else begin
          cur_nxt   = alu_res[OFF_W-1:0];
          state_nxt = S_RD;
        end
      end
      // free block: compare size with request
      S_CHK: begin
        alu_op = ALU_SUB;
        alu_a  = sz_r;
        alu_b  = req_r;
        if (alu_zero) begin
          state_nxt = S_EXW;
        end else if (!alu_neg) begin
          state_nxt = S_SPL1;
        end else if (last_r) begin
          st_nxt    = ST_NOFIT;
          state_nxt = S_RESP;
        end else begin
          cur_nxt   = next_r;
          state_nxt = S_RD;
        end
      end
      // remainder size, must leave room for a header and a payload
      S_SPL1: begin
        alu_op = ALU_SUB_HDR;
        alu_a  = sz_r;
        alu_b  = req_r;
        if (alu_neg || alu_zero) begin
          st_nxt    = ST_NOFIT;
          state_nxt = S_RESP;
        end else begin
          rsz_nxt   = alu_res[SIZE_W-1:0];
          state_nxt = S_SPL2;
        end
      end
      // remainder header offset
      S_SPL2: begin
        alu_op      = ALU_ADD_HDR;
        alu_a       = cur_r;
        alu_b       = req_r;
        rst_nxt     = alu_res[OFF_W-1:0];
        rest_ok_nxt = (alu_res < SUM_W'(ARENA_UNITS));
        state_nxt   = S_WR1;
      end
      S_WR1: begin
        if (rest_ok_r) begin
          hdr_req.wr_size_en = 1'b1;
          hdr_req.wr_free_en = 1'b1;
          hdr_req.wr_addr    = rst_r;
          hdr_req.wr_size    = rsz_r;
          hdr_req.wr_free    = 1'b1;
        end
        state_nxt = S_WR2;
      end
      S_WR2: begin
        hdr_req.wr_size_en = 1'b1;
        hdr_req.wr_free_en = 1'b1;
        hdr_req.wr_addr    = cur_r;
        hdr_req.wr_size    = req_r;
        hdr_req.wr_free    = 1'b0;
        alu_op             = ALU_ADD_HDR;
        alu_a              = cur_r;
        pay_nxt            = alu_res[OFF_W-1:0];
        st_nxt             = ST_SPLIT;
        state_nxt          = S_RESP;
      end
      S_EXW: begin
        hdr_req.wr_free_en = 1'b1;
        hdr_req.wr_addr    = cur_r;
        hdr_req.wr_free    = 1'b0;
        alu_op             = ALU_ADD_HDR;
        alu_a              = cur_r;
        pay_nxt            = alu_res[OFF_W-1:0];
        st_nxt             = ST_EXACT;
        state_nxt          = S_RESP;
      end
      // hand over to the output register
      S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = st_r;
          out_addr_nxt   = pay_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r        <= req_nxt;
    cur_r        <= cur_nxt;
    next_r       <= next_nxt;
    sz_r         <= sz_nxt;
    fr_r         <= fr_nxt;
    last_r       <= last_nxt;
    rsz_r        <= rsz_nxt;
    rst_r        <= rst_nxt;
    rest_ok_r    <= rest_ok_nxt;
    st_r         <= st_nxt;
    pay_r        <= pay_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
  end

  // store is never read and written in the same cycle
  a_store_excl: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_req.rd_en |-> !(hdr_req.wr_size_en || hdr_req.wr_free_en))
    else $error("header store read and write collide");

  // only a free block is ever handed out by exact fit
  a_exact_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXW) |-> fr_r)
    else $error("exact fit on a used block");

  // a split leaves a non-empty remainder
  a_split_rest: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR1) |-> (rsz_r != '0))
    else $error("split with empty remainder");

  // failed allocations and frees report a zero address
  a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ((out_status_r == ST_NOFIT) || (out_status_r == ST_FREE)))
      |-> (out_addr_r == '0))
    else $error("non-zero address on failed or free request");

  // an accepted request blocks the input on the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("request accepted while busy");

endmodule
